>>> rtl/gfpar_pkg.sv
// ----------------------------------------------------------------------------
// gfpar_pkg
// Shared types and fixed constants for the GF(2^8) two-parity dot product.
// ----------------------------------------------------------------------------
`default_nettype none

package gfpar_pkg;

    localparam int BYTE_W      = 8;
    localparam int NIBBLE_W    = 4;
    localparam int ADDR_W      = 11;   // table_address port width
    localparam int COUNT_W     = 6;    // source_count register width
    localparam int HALF_STRIDE = 16;   // entries per nibble table
    localparam int SRC_STRIDE  = 32;   // entries per source (low + high table)
    localparam int NUM_BANKS   = 4;    // {parity, half}

    // Kind of input item
    typedef enum logic
    {
        OP_TABLE = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage : gfpar_pkg

`default_nettype wire

>>> rtl/gf256_two_parity_dot_product.sv
// ----------------------------------------------------------------------------
// gf256_two_parity_dot_product
// Erasure-code parity engine over GF(2^8) built on split nibble product tables.
// ----------------------------------------------------------------------------
// Load the product tables first with table items (op = OP_TABLE), one byte per
// transfer at table_address = parity*(MAX_SOURCES*32) + source*32 + half*16 +
// nibble. Then stream data items (op = OP_DATA), one source byte per transfer
// in source order; after source_count bytes one result transfer carries both
// parity bytes and the accumulators clear. A new item is taken every cycle
// unless in_stall is high: each data byte passes through the table read stage
// and then the accumulate stage, and the four lookups come from four
// single-port table banks read in parallel. The output register lets the next
// item enter while a result waits; input stall rises only when a completed
// position must be placed while the output register is still full and stalled.
// No clearing pass runs after reset; unwritten table entries read as undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_two_parity_dot_product
#(
    parameter int MAX_SOURCES = 32
)
(
    input  wire                              clk,
    input  wire                              rst_n,

    // configuration
    input  wire                              source_count_write,
    input  wire [gfpar_pkg::COUNT_W-1:0]     source_count,

    // input channel
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire                              op,
    input  wire [gfpar_pkg::ADDR_W-1:0]      table_address,
    input  wire [gfpar_pkg::BYTE_W-1:0]      table_byte,
    input  wire [gfpar_pkg::BYTE_W-1:0]      data_byte,

    // output channel
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [gfpar_pkg::BYTE_W-1:0]     parity0,
    output logic [gfpar_pkg::BYTE_W-1:0]     parity1
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int PARITY_STRIDE = MAX_SOURCES * gfpar_pkg::SRC_STRIDE;
    localparam int TABLE_DEPTH   = 2 * PARITY_STRIDE;
    localparam int BANK_DEPTH    = MAX_SOURCES * gfpar_pkg::HALF_STRIDE;
    localparam int BANK_AW       = $clog2(BANK_DEPTH);
    localparam int SRC_W         = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int FULL_AW       = $clog2(TABLE_DEPTH) + 1;
    localparam int EXT_W         = (FULL_AW > gfpar_pkg::ADDR_W) ? FULL_AW
                                                                 : gfpar_pkg::ADDR_W;
    localparam int CMP_BASE      = (SRC_W > gfpar_pkg::COUNT_W) ? SRC_W
                                                                : gfpar_pkg::COUNT_W;
    localparam int CMP_W         = CMP_BASE + 1;
    localparam int IDX_W         = SRC_W + gfpar_pkg::NIBBLE_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [gfpar_pkg::COUNT_W-1:0] source_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= gfpar_pkg::COUNT_W'(1);
        end
        else if (source_count_write)
        begin
            source_count_reg <= source_count;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_last_reg;
    logic s1_blocked;
    logic in_accept;
    logic data_accept;
    logic table_accept;
    logic out_valid_reg;
    logic out_load;

    // Stage 1 can only stall when it holds a completed position and the
    // output register is full and not being drained this cycle.
    assign s1_blocked   = s1_valid_reg & s1_last_reg & out_valid_reg & out_stall;
    assign in_stall     = s1_blocked;
    assign in_accept    = in_valid & ~s1_blocked;
    assign data_accept  = in_accept & (gfpar_pkg::op_t'(op) == gfpar_pkg::OP_DATA);
    assign table_accept = in_accept & (gfpar_pkg::op_t'(op) == gfpar_pkg::OP_TABLE);
    assign out_load     = s1_valid_reg & s1_last_reg & ~s1_blocked;

    // ------------------------------------------------------------------
    // Position counter and end-of-position decision (stage 0)
    // ------------------------------------------------------------------
    logic [SRC_W-1:0] source_index_reg;
    logic [SRC_W-1:0] source_index_next;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] count_eff;
    logic [CMP_W-1:0] index_plus_one;
    logic             is_last;

    always_comb
    begin
        count_ext = CMP_W'(source_count_reg);
        // Clamp count to 1..MAX_SOURCES
        if (count_ext == '0)
        begin
            count_eff = CMP_W'(1);
        end
        else if (count_ext > CMP_W'(MAX_SOURCES))
        begin
            count_eff = CMP_W'(MAX_SOURCES);
        end
        else
        begin
            count_eff = count_ext;
        end
        index_plus_one = CMP_W'(source_index_reg) + CMP_W'(1);
        is_last        = (index_plus_one >= count_eff);

        source_index_next = source_index_reg;
        if (data_accept)
        begin
            source_index_next = is_last ? '0 : SRC_W'(index_plus_one);
        end
    end

    // ------------------------------------------------------------------
    // Table write address decode
    // ------------------------------------------------------------------
    logic [EXT_W-1:0]   wr_addr_ext;
    logic [EXT_W-1:0]   wr_offset;
    logic               wr_parity;
    logic               wr_half;
    logic               wr_in_range;
    logic [IDX_W-1:0]   wr_index;
    logic [BANK_AW-1:0] wr_bank_addr;
    logic [1:0]         wr_bank;

    always_comb
    begin
        wr_addr_ext  = EXT_W'(table_address);
        wr_in_range  = (wr_addr_ext < EXT_W'(TABLE_DEPTH));
        wr_parity    = (wr_addr_ext >= EXT_W'(PARITY_STRIDE));
        wr_offset    = wr_parity ? (wr_addr_ext - EXT_W'(PARITY_STRIDE)) : wr_addr_ext;
        wr_half      = wr_offset[gfpar_pkg::NIBBLE_W];
        // offset / 32 selects the source, the low four bits the nibble
        wr_index     = {SRC_W'(wr_offset >> (gfpar_pkg::NIBBLE_W + 1)),
                        wr_offset[gfpar_pkg::NIBBLE_W-1:0]};
        wr_bank_addr = BANK_AW'(wr_index);
        wr_bank      = {wr_parity, wr_half};
    end

    // ------------------------------------------------------------------
    // Table banks: {parity0 low, parity0 high, parity1 low, parity1 high}
    // One write or one read per bank per cycle, read data registered.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   rd_index_lo;
    logic [IDX_W-1:0]   rd_index_hi;
    logic [BANK_AW-1:0] rd_addr_lo;
    logic [BANK_AW-1:0] rd_addr_hi;

    assign rd_index_lo = {source_index_reg, data_byte[gfpar_pkg::NIBBLE_W-1:0]};
    assign rd_index_hi = {source_index_reg,
                          data_byte[gfpar_pkg::BYTE_W-1:gfpar_pkg::NIBBLE_W]};
    assign rd_addr_lo  = BANK_AW'(rd_index_lo);
    assign rd_addr_hi  = BANK_AW'(rd_index_hi);

    for (genvar b = 0; b < gfpar_pkg::NUM_BANKS; b++)
    begin : g_bank
        gfpar_pkg::byte_t   bank_mem [BANK_DEPTH];
        gfpar_pkg::byte_t   rd_data_reg;
        logic [BANK_AW-1:0] rd_addr;

        // Odd banks hold the high-nibble tables
        assign rd_addr = ((b % 2) != 0) ? rd_addr_hi : rd_addr_lo;

        always_ff @(posedge clk)
        begin
            if (table_accept && wr_in_range && (wr_bank == 2'(b)))
            begin
                bank_mem[wr_bank_addr] <= table_byte;
            end
            // Hold read data while stage 1 waits
            if (data_accept)
            begin
                rd_data_reg <= bank_mem[rd_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: accumulate and hand off completed positions
    // ------------------------------------------------------------------
    gfpar_pkg::byte_t acc0_reg;
    gfpar_pkg::byte_t acc1_reg;
    gfpar_pkg::byte_t acc0_next;
    gfpar_pkg::byte_t acc1_next;
    gfpar_pkg::byte_t sum0;
    gfpar_pkg::byte_t sum1;
    gfpar_pkg::byte_t parity0_reg;
    gfpar_pkg::byte_t parity1_reg;
    logic             out_valid_next;

    always_comb
    begin
        sum0 = acc0_reg ^ g_bank[0].rd_data_reg ^ g_bank[1].rd_data_reg;
        sum1 = acc1_reg ^ g_bank[2].rd_data_reg ^ g_bank[3].rd_data_reg;

        acc0_next = acc0_reg;
        acc1_next = acc1_reg;
        if (s1_valid_reg && !s1_blocked)
        begin
            // Drop the sums at the end of a position, else keep them
            acc0_next = s1_last_reg ? '0 : sum0;
            acc1_next = s1_last_reg ? '0 : sum1;
        end

        // Stage 1 refills only from an accepted data item
        s1_valid_next = s1_blocked ? s1_valid_reg : data_accept;

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_index_reg <= '0;
            s1_valid_reg     <= 1'b0;
            s1_last_reg      <= 1'b0;
            acc0_reg         <= '0;
            acc1_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            source_index_reg <= source_index_next;
            s1_valid_reg     <= s1_valid_next;
            if (data_accept)
            begin
                s1_last_reg <= is_last;
            end
            acc0_reg      <= acc0_next;
            acc1_reg      <= acc1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            parity0_reg <= sum0;
            parity1_reg <= sum1;
        end
    end

    assign out_valid = out_valid_reg;
    assign parity0   = parity0_reg;
    assign parity1   = parity1_reg;

endmodule : gf256_two_parity_dot_product

`default_nettype wire
